// File: rtl/sgsb_pkg.sv
`default_nettype none

package sgsb_pkg;

  // default sizing, handed to the top level parameters
  localparam int ADDR_BITS_DEF = 64;
  localparam int MAX_SEGS_DEF  = 64;

  // fixed field widths
  localparam int LEN_BITS   = 32;
  localparam int CFG_BITS   = 32;
  localparam int COUNT_BITS = 7;

  // register indexes on the config port
  localparam logic [1:0] REG_MAX_SEG_BYTES  = 2'd0;
  localparam logic [1:0] REG_MAX_XFER_BYTES = 2'd1;
  localparam logic [1:0] REG_MAX_SEG_COUNT  = 2'd2;
  localparam logic [1:0] REG_BYTE_SWAP      = 2'd3;

  // register reset values
  localparam logic [CFG_BITS-1:0]   MAX_SEG_BYTES_RST  = '1;
  localparam logic [CFG_BITS-1:0]   MAX_XFER_BYTES_RST = '0;
  localparam logic [COUNT_BITS-1:0] MAX_SEG_COUNT_RST  = 7'd64;

  // stop cause codes
  localparam logic [1:0] CAUSE_END_OF_BUFFER = 2'd0;
  localparam logic [1:0] CAUSE_COUNT_LIMIT   = 2'd1;
  localparam logic [1:0] CAUSE_BYTE_LIMIT    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load_run;
    logic merge;
    logic split;
    logic limit;
    logic trim;
    logic emit;
    logic count_stop;
    logic emit_final;
  } sgsb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic halted;
    logic open_valid;
    logic contig;
    logic pend;
    logic limit_hit;
    logic count_full;
    logic fin;
    logic out_free;
  } sgsb_stat_t;

endpackage

`default_nettype wire

// File: rtl/sgsb_ctrl.sv
`default_nettype none

module sgsb_ctrl
  import sgsb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       run_valid,
  output logic       run_ready,
  input  sgsb_stat_t stat,
  output sgsb_cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_MERGE = 7'b0000010,
    S_SPLIT = 7'b0000100,
    S_LIMIT = 7'b0001000,
    S_TRIM  = 7'b0010000,
    S_COUNT = 7'b0100000,
    S_FINAL = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign run_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (run_valid) begin
          cmd.load_run = 1'b1;
          // a halted block drops the run; the datapath re-arms on a final one
          state_next   = stat.halted ? S_IDLE : S_MERGE;
        end
      end
      S_MERGE: begin
        if (stat.open_valid && !stat.contig) begin
          state_next = S_COUNT;
        end else begin
          cmd.merge  = 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        cmd.split  = 1'b1;
        state_next = S_LIMIT;
      end
      S_LIMIT: begin
        if (stat.limit_hit) begin
          cmd.limit  = 1'b1;
          state_next = S_TRIM;
        end else if (stat.pend) begin
          state_next = S_COUNT;
        end else if (stat.fin) begin
          state_next = S_FINAL;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = S_FINAL;
      end
      S_COUNT: begin
        if (stat.count_full) begin
          cmd.count_stop = 1'b1;
          state_next     = S_FINAL;
        end else if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_MERGE;
        end
      end
      S_FINAL: begin
        if (stat.out_free) begin
          cmd.emit_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/sgsb_dpath.sv
`default_nettype none

module sgsb_dpath
  import sgsb_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int MAX_SEGS  = MAX_SEGS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic [63:0]         run_addr,
  input  logic [LEN_BITS-1:0] run_len,
  input  logic                run_is_final,
  output logic                seg_valid,
  input  logic                seg_ready,
  output logic [63:0]         seg_addr,
  output logic [LEN_BITS-1:0] seg_len,
  output logic                seg_is_final,
  output logic [LEN_BITS-1:0] bytes_covered,
  output logic [1:0]          stop_cause,
  input  sgsb_cmd_t           cmd,
  output sgsb_stat_t          stat
);

  localparam int CNT_BITS = $clog2(MAX_SEGS + 1);

  logic [CFG_BITS-1:0]   max_seg_cfg;
  logic [CFG_BITS-1:0]   max_xfer_cfg;
  logic [COUNT_BITS-1:0] max_cnt_cfg;
  logic                  swap_cfg;

  logic [ADDR_BITS-1:0] open_addr;
  logic [ADDR_BITS-1:0] pa;
  logic [LEN_BITS:0]    cur;
  logic [LEN_BITS:0]    pl;
  logic [LEN_BITS+1:0]  tot;
  logic [LEN_BITS+1:0]  over;
  logic                 open_valid;
  logic                 pend;
  logic                 fin;
  logic                 halted;
  logic [1:0]           cause;
  logic [CNT_BITS-1:0]  seg_emitted;

  logic [LEN_BITS-1:0]   maxseg;
  logic [LEN_BITS-1:0]   limit;
  logic [COUNT_BITS-1:0] cnt_clamp;
  logic [CNT_BITS-1:0]   cnt_eff;

  logic [ADDR_BITS-1:0] open_end;
  logic [ADDR_BITS-1:0] split_addr;
  logic [LEN_BITS:0]    split_rem;
  logic [LEN_BITS+1:0]  split_tot;
  logic                 over_seg;
  logic                 limit_hit;
  logic [LEN_BITS:0]    trim_len;
  logic                 count_full;
  logic                 out_free;

  logic [63:0]         addr_wide;
  logic [63:0]         addr_swap;
  logic [LEN_BITS-1:0] len_swap;
  logic [63:0]         addr_out;
  logic [LEN_BITS-1:0] len_out;

  // zero values of the limit registers mean one byte and no limit
  assign maxseg = (max_seg_cfg == '0) ? LEN_BITS'(1) : max_seg_cfg;
  assign limit  = (max_xfer_cfg == '0) ? '1 : max_xfer_cfg;

  always_comb begin
    if (max_cnt_cfg == '0) begin
      cnt_clamp = COUNT_BITS'(1);
    end else if (max_cnt_cfg > COUNT_BITS'(MAX_SEGS)) begin
      cnt_clamp = COUNT_BITS'(MAX_SEGS);
    end else begin
      cnt_clamp = max_cnt_cfg;
    end
  end
  assign cnt_eff = cnt_clamp[CNT_BITS-1:0];

  assign open_end   = open_addr + ADDR_BITS'(cur);
  assign split_addr = open_addr + ADDR_BITS'(maxseg);
  assign split_rem  = cur - {1'b0, maxseg};
  assign split_tot  = tot - {1'b0, cur} + {2'b00, maxseg};
  assign over_seg   = cur > {1'b0, maxseg};
  assign limit_hit  = tot >= {2'b00, limit};
  assign trim_len   = (over > {1'b0, cur}) ? '0 : cur - over[LEN_BITS:0];
  assign count_full = ({1'b0, seg_emitted} + (CNT_BITS + 1)'(1)) >= {1'b0, cnt_eff};
  assign out_free   = !seg_valid || seg_ready;

  assign addr_wide = 64'(open_addr);
  assign addr_swap = {<<8{addr_wide}};
  assign len_swap  = {<<8{cur[LEN_BITS-1:0]}};
  assign addr_out  = swap_cfg ? addr_swap : addr_wide;
  assign len_out   = swap_cfg ? len_swap : cur[LEN_BITS-1:0];

  assign stat.halted     = halted;
  assign stat.open_valid = open_valid;
  assign stat.contig     = (open_end == pa);
  assign stat.pend       = pend;
  assign stat.limit_hit  = limit_hit;
  assign stat.count_full = count_full;
  assign stat.fin        = fin;
  assign stat.out_free   = out_free;

  // config and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      max_seg_cfg  <= MAX_SEG_BYTES_RST;
      max_xfer_cfg <= MAX_XFER_BYTES_RST;
      max_cnt_cfg  <= MAX_SEG_COUNT_RST;
      swap_cfg     <= 1'b0;
      open_valid   <= 1'b0;
      pend         <= 1'b0;
      halted       <= 1'b0;
      cause        <= CAUSE_END_OF_BUFFER;
      seg_emitted  <= '0;
      tot          <= '0;
      seg_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MAX_SEG_BYTES:  max_seg_cfg  <= cfg_data;
          REG_MAX_XFER_BYTES: max_xfer_cfg <= cfg_data;
          REG_MAX_SEG_COUNT:  max_cnt_cfg  <= cfg_data[COUNT_BITS-1:0];
          REG_BYTE_SWAP:      swap_cfg     <= cfg_data[0];
          default: ;
        endcase
      end

      if (cmd.load_run) begin
        pend  <= 1'b1;
        cause <= CAUSE_END_OF_BUFFER;
        if (halted && run_is_final) begin
          halted <= 1'b0;
        end
      end

      if (cmd.merge) begin
        pend       <= 1'b0;
        open_valid <= 1'b1;
        tot        <= tot + {1'b0, pl};
      end

      if (cmd.split && over_seg) begin
        pend <= 1'b1;
        tot  <= split_tot;
      end

      if (cmd.limit) begin
        tot   <= {2'b00, limit};
        cause <= CAUSE_BYTE_LIMIT;
      end

      if (cmd.count_stop) begin
        cause <= CAUSE_COUNT_LIMIT;
      end

      if (cmd.emit) begin
        seg_emitted <= seg_emitted + CNT_BITS'(1);
        open_valid  <= 1'b0;
      end

      if (cmd.emit_final) begin
        open_valid  <= 1'b0;
        tot         <= '0;
        seg_emitted <= '0;
        halted      <= (cause != CAUSE_END_OF_BUFFER) && !fin;
      end

      if (cmd.emit || cmd.emit_final) begin
        seg_valid <= 1'b1;
      end else if (seg_ready) begin
        seg_valid <= 1'b0;
      end
    end
  end

  // segment payload and output register
  always_ff @(posedge clk) begin
    if (cmd.load_run) begin
      pa  <= run_addr[ADDR_BITS-1:0];
      pl  <= {1'b0, run_len};
      fin <= run_is_final;
    end

    if (cmd.merge) begin
      if (!open_valid) begin
        open_addr <= pa;
        cur       <= pl;
      end else begin
        cur <= cur + pl;
      end
    end

    if (cmd.split && over_seg) begin
      pa  <= split_addr;
      pl  <= split_rem;
      cur <= {1'b0, maxseg};
    end

    if (cmd.limit) begin
      over <= tot - {2'b00, limit};
    end

    if (cmd.trim) begin
      cur <= trim_len;
    end

    if (cmd.emit) begin
      seg_addr      <= addr_out;
      seg_len       <= len_out;
      seg_is_final  <= 1'b0;
      bytes_covered <= '0;
      stop_cause    <= CAUSE_END_OF_BUFFER;
    end

    if (cmd.emit_final) begin
      seg_addr      <= addr_out;
      seg_len       <= len_out;
      seg_is_final  <= 1'b1;
      bytes_covered <= tot[LEN_BITS-1:0];
      stop_cause    <= cause;
    end
  end

endmodule

`default_nettype wire

// File: rtl/scatter_gather_segment_builder.sv
// Scatter-gather segment builder: turns a stream of physical memory runs
// (address, length, final mark) into a list of DMA segments. A run that
// starts where the open segment ends is merged into it; any other run closes
// the open segment and opens a new one. Segments longer than the segment size
// register are cut into chunks. A transfer ends at the final run (cause 0),
// when the segment count limit is hit (cause 1) or when the byte limit is
// reached (cause 2, last segment trimmed); only the final segment carries
// the byte total and the cause. After a limit stop, runs are dropped up to
// and including the next final run. Each run is handled by a serial
// controller that steps through the merge, split and limit arithmetic and
// takes no new run until it is back in idle; a run that does not continue
// the open segment first closes it, each chunk cut off by a split is emitted
// before the rest, a byte limit adds a trim step and a dropped run goes back
// to idle. Results leave through a one-entry output register, so a stalled
// output holds the controller only when a second segment is ready to go. The
// user must write configuration through the plain write port while the block
// is idle, so it applies from the next run; the block does not enforce this.
`default_nettype none

module scatter_gather_segment_builder
  import sgsb_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int MAX_SEGS  = MAX_SEGS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // config write port
  input  logic                cfg_write,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data,
  // run input channel
  input  logic                run_valid,
  output logic                run_ready,
  input  logic [63:0]         run_addr,
  input  logic [LEN_BITS-1:0] run_len,
  input  logic                run_is_final,
  // segment output channel
  output logic                seg_valid,
  input  logic                seg_ready,
  output logic [63:0]         seg_addr,
  output logic [LEN_BITS-1:0] seg_len,
  output logic                seg_is_final,
  output logic [LEN_BITS-1:0] bytes_covered,
  output logic [1:0]          stop_cause
);

  // command and status between controller and datapath
  sgsb_cmd_t  cmd;
  sgsb_stat_t stat;

  sgsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .run_valid (run_valid),
    .run_ready (run_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sgsb_dpath #(
    .ADDR_BITS (ADDR_BITS),
    .MAX_SEGS  (MAX_SEGS)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .run_addr      (run_addr),
    .run_len       (run_len),
    .run_is_final  (run_is_final),
    .seg_valid     (seg_valid),
    .seg_ready     (seg_ready),
    .seg_addr      (seg_addr),
    .seg_len       (seg_len),
    .seg_is_final  (seg_is_final),
    .bytes_covered (bytes_covered),
    .stop_cause    (stop_cause),
    .cmd           (cmd),
    .stat          (stat)
  );

  // a segment is only loaded into a free output register
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_final) |-> stat.out_free)
    else $error("segment loaded over an untaken result");

  // a run that is not dropped keeps the input closed for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (run_valid && run_ready && !stat.halted) |=> !run_ready)
    else $error("input reopened while a run is in work");

  // the closing segment shows up as final on the next cycle
  a_final_shown: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_final |=> (seg_valid && seg_is_final))
    else $error("final segment not presented");

  // only the closing segment carries a total and a cause
  a_non_final_clean: assert property (@(posedge clk) disable iff (rst)
    (seg_valid && !seg_is_final) |-> (stop_cause == CAUSE_END_OF_BUFFER &&
                                      bytes_covered == '0))
    else $error("non-final segment carries a total or a cause");

endmodule

`default_nettype wire
